FILE: rtl/sapf_pkg.sv
// Shared constants, types and arithmetic helpers for the stereo allpass filter.
package sapf_pkg;

    localparam int MAX_DELAY   = 4096;
    localparam int SAMPLE_BITS = 24;

    localparam int ADDR_W  = $clog2(MAX_DELAY);
    localparam int GAIN_W  = 16;
    localparam int LEN_W   = 13;
    localparam int CMP_W   = (LEN_W > ADDR_W + 1) ? LEN_W : ADDR_W + 1;
    localparam int COEF_W  = GAIN_W + 1;
    localparam int PROD_W  = SAMPLE_BITS + COEF_W;
    localparam int FRAC_W  = GAIN_W - 1;
    localparam int RND_W   = PROD_W + 1 - FRAC_W;
    localparam int SUM_W   = RND_W + 1;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register index as carried by paddr[2]
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    localparam logic signed [GAIN_W-1:0] GAIN_RST = GAIN_W'(16384);
    localparam logic [LEN_W-1:0]         LEN_RST  = LEN_W'(1024);

    localparam logic signed [PROD_W:0]  RND_HALF = (PROD_W + 1)'(1 << (FRAC_W - 1));
    localparam logic signed [SUM_W-1:0] SUM_HI   =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_LO   = ~SUM_HI;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_W-1:0]             t_addr;

    // Clamp a wide sum into the sample range
    function automatic t_sample f_sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_HI) begin
            return SAMPLE_BITS'(SUM_HI);
        end else if (v < SUM_LO) begin
            return SAMPLE_BITS'(SUM_LO);
        end
        return SAMPLE_BITS'(v);
    endfunction

endpackage

FILE: rtl/stereo_allpass_filter_unit.sv
// Stereo Schroeder allpass filter: sequencer, shared multiply-add unit, delay stores.
// The result is registered in S_DONE once the output register is free; a new request is
// taken only in S_IDLE, after the last one has been passed on. Each channel takes five
// steps through the single multiplier and saturating adder shared by both channels.
// Reset: synchronous; both delay stores are then zeroed one entry per cycle over all
// 4096 entries, with o_in_ready low; register writes are taken throughout.
module stereo_allpass_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sapf_pkg::APB_AW-1:0]    paddr,
    input  logic [sapf_pkg::APB_DW-1:0]    pwdata,
    output logic [sapf_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sapf_pkg::t_sample              i_left_sample,
    input  sapf_pkg::t_sample              i_right_sample,
    input  logic [1:0]                     i_channel_mask,
    input  logic                           i_block_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sapf_pkg::t_sample              o_left_out,
    output sapf_pkg::t_sample              o_right_out,
    output logic                           o_left_valid,
    output logic                           o_right_valid,
    output logic                           o_block_end_out
);
    import sapf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL_W,
        S_ADD_W,
        S_MUL_Y,
        S_ADD_Y,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic signed [GAIN_W-1:0] r_gain;
    logic [LEN_W-1:0]         r_len;
    logic                     cfg_wr;
    logic                     len_wr;

    // Request and channel state
    t_addr            r_clr;
    t_addr            r_pos_l;
    t_addr            r_pos_r;
    logic             r_ch;
    logic [1:0]       r_mask;
    logic             r_blk;
    t_sample          r_x_l;
    t_sample          r_x_r;
    t_sample          r_y_l;
    t_sample          r_y_r;
    t_sample          r_w;
    logic signed [PROD_W-1:0] r_prod;

    // Delay stores
    t_sample mem_l [MAX_DELAY];
    t_sample mem_r [MAX_DELAY];
    t_sample r_rd_l;
    t_sample r_rd_r;

    // Datapath
    t_addr                    cur_pos;
    t_addr                    mem_addr;
    t_sample                  mem_wdata;
    logic                     we_l;
    logic                     we_r;
    logic                     rd_en;
    t_sample                  d_val;
    t_sample                  x_val;
    logic signed [COEF_W-1:0] g_pos;
    logic signed [COEF_W-1:0] g_neg;
    t_sample                  mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W:0]   prod_r;
    logic signed [RND_W-1:0]  rnd;
    t_sample                  add_b;
    logic signed [SUM_W-1:0]  sum;
    t_sample                  sat_val;
    logic [CMP_W-1:0]         len_c;
    logic [CMP_W-1:0]         eff_len;
    logic [CMP_W-1:0]         pos_inc;
    t_addr                    n_pos;
    logic                     out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign len_wr = cfg_wr && (paddr[2] == REG_LEN);

    always_comb begin
        unique case (paddr[2])
            REG_GAIN: prdata = {{(APB_DW - GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
            REG_LEN:  prdata = {{(APB_DW - LEN_W){1'b0}}, r_len};
            default:  prdata = '0;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !o_out_valid || i_out_ready;

    // Effective length: zero acts as one, anything above the store depth as the depth
    assign len_c   = CMP_W'(r_len);
    assign eff_len = (r_len == '0) ? CMP_W'(1)
                   : (len_c > CMP_W'(MAX_DELAY)) ? CMP_W'(MAX_DELAY) : len_c;

    assign cur_pos = r_ch ? r_pos_r : r_pos_l;
    assign pos_inc = CMP_W'(cur_pos) + CMP_W'(1);
    assign n_pos   = (pos_inc >= eff_len) ? '0 : pos_inc[ADDR_W-1:0];

    assign d_val = r_ch ? r_rd_r : r_rd_l;
    assign x_val = r_ch ? r_x_r : r_x_l;

    // Shared multiplier: d*g first, then w*(-g)
    assign g_pos = COEF_W'(r_gain);
    assign g_neg = -g_pos;
    assign mul_a = (r_state == S_MUL_W) ? d_val : r_w;
    assign mul_b = (r_state == S_MUL_W) ? g_pos : g_neg;
    assign mul_p = mul_a * mul_b;

    // Shared round, add and saturate
    assign prod_r  = (PROD_W + 1)'(r_prod) + RND_HALF;
    assign rnd     = $signed(prod_r[PROD_W:FRAC_W]);
    assign add_b   = (r_state == S_ADD_W) ? x_val : d_val;
    assign sum     = SUM_W'(rnd) + SUM_W'(add_b);
    assign sat_val = f_sat(sum);

    assign mem_addr  = (r_state == S_CLEAR) ? r_clr : cur_pos;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : sat_val;
    assign we_l      = (r_state == S_CLEAR) || (r_state == S_ADD_W && !r_ch);
    assign we_r      = (r_state == S_CLEAR) || (r_state == S_ADD_W && r_ch);
    assign rd_en     = (r_state == S_READ);

    always_ff @(posedge i_clk) begin
        if (we_l) begin
            mem_l[mem_addr] <= mem_wdata;
        end
        if (rd_en && !r_ch) begin
            r_rd_l <= mem_l[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_r) begin
            mem_r[mem_addr] <= mem_wdata;
        end
        if (rd_en && r_ch) begin
            r_rd_r <= mem_r[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_gain          <= GAIN_RST;
            r_len           <= LEN_RST;
            r_pos_l         <= '0;
            r_pos_r         <= '0;
            r_ch            <= 1'b0;
            o_out_valid     <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(MAX_DELAY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x_l  <= i_left_sample;
                        r_x_r  <= i_right_sample;
                        r_mask <= i_channel_mask;
                        r_blk  <= i_block_end;
                        r_y_l  <= '0;
                        r_y_r  <= '0;
                        r_ch   <= !i_channel_mask[0];
                        if (i_channel_mask != 2'b00) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MUL_W;
                end
                S_MUL_W: begin
                    r_prod  <= mul_p;
                    r_state <= S_ADD_W;
                end
                S_ADD_W: begin
                    r_w     <= sat_val;
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_prod  <= mul_p;
                    r_state <= S_ADD_Y;
                end
                S_ADD_Y: begin
                    // a length write in this cycle rewinds the positions instead
                    if (r_ch) begin
                        r_y_r <= sat_val;
                        if (!len_wr) begin
                            r_pos_r <= n_pos;
                        end
                    end else begin
                        r_y_l <= sat_val;
                        if (!len_wr) begin
                            r_pos_l <= n_pos;
                        end
                    end
                    // advance to the right channel if it is enabled too
                    if (!r_ch && r_mask[1]) begin
                        r_ch    <= 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_left_out      <= r_y_l;
                        o_right_out     <= r_y_r;
                        o_left_valid    <= r_mask[0];
                        o_right_valid   <= r_mask[1];
                        o_block_end_out <= r_blk;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                    REG_LEN: begin
                        r_len   <= pwdata[LEN_W-1:0];
                        r_pos_l <= '0;
                        r_pos_r <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    a_pos_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos_l) < eff_len)
        else $error("left position beyond delay length");

    a_pos_r_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos_r) < eff_len)
        else $error("right position beyond delay length");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_left_valid || o_left_out == '0) &&
                         (o_right_valid || o_right_out == '0)))
        else $error("disabled channel output not zero");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready still high after a request was taken");

endmodule
